### rtl/dmxmap_pkg.sv
// Shared types, constants and lookup functions for the DMX channel to motor target map.
package dmxmap_pkg;

    // Byte-padded widths of the stream words.
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 112;

    // Channel thresholds.
    localparam logic [7:0] ROT_LOW_MAX   = 8'd55;
    localparam logic [7:0] ROT_BAND_SPLIT = 8'd155;
    localparam logic [7:0] PRISM_IN_MIN  = 8'd125;
    localparam logic [7:0] COLOR_POS_MAX = 8'd200;
    localparam logic [7:0] COLOR_REV_MAX = 8'd224;
    localparam logic [7:0] STROBE_MIN    = 8'd55;

    // Fixed targets and speeds.
    localparam logic signed [12:0] ROT_FWD        = 13'sd3000;
    localparam logic signed [12:0] ROT_REV        = -13'sd3000;
    localparam logic signed [12:0] ROT_STOP       = 13'sd0;
    localparam logic [8:0]         PRISM_IN_POS   = 9'd257;
    localparam logic [12:0]        PRISM_SPD_IDLE = 13'd5000;
    localparam logic [10:0]        GOBO_SPD_IDLE  = 11'd1500;
    localparam logic [12:0]        SPD_BASE_P     = 13'd500;
    localparam logic [10:0]        SPD_BASE_G     = 11'd500;
    localparam logic [15:0]        SHUT_CLOSE_OFS = 16'd100;

    // Reciprocal multipliers for constant division.
    localparam logic [11:0] RECIP_201_K19 = 12'd2609;   // x/201, x < 4333
    localparam logic [12:0] RECIP_11_K16  = 13'd5958;   // x/11,  x < 32768
    localparam logic [15:0] RECIP_67_K22  = 16'd62602;  // x/67,  x < 139810

    // One input word, last declared field in the lowest bits.
    typedef struct packed {
        logic signed [15:0] shutter_position;
        logic [31:0]        now_ms;
        logic [7:0]         gobo_rotate_channel;
        logic [7:0]         gobo_channel;
        logic [7:0]         strobe_channel;
        logic [7:0]         focus_channel;
        logic [7:0]         prism_switch_channel;
        logic [7:0]         prism_rotate_channel;
        logic [7:0]         shutter_channel;
        logic [7:0]         color_channel;
    } t_in_word;

    // One result word, last declared field in the lowest bits, zero padded at the top.
    typedef struct packed {
        logic [4:0]         pad;
        logic               strobe_toggle;
        logic [10:0]        gobo_rotate_speed;
        logic [12:0]        prism_rotate_speed;
        logic signed [12:0] gobo_rotate_target;
        logic [10:0]        gobo_target;
        logic [6:0]         shutter_two_target;
        logic [8:0]         focus_target;
        logic [8:0]         prism_switch_target;
        logic signed [12:0] prism_rotate_target;
        logic [6:0]         shutter_one_target;
        logic signed [12:0] color_target;
    } t_out_word;

    // Strobe timer state.
    typedef struct packed {
        logic [31:0] last_flash;
        logic        open;
    } t_strobe_state;

    // floor(x/255) for x below 65280.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

    // Colour wheel slot positions.
    function automatic logic [10:0] color_slot_pos(input logic [3:0] idx);
        logic [10:0] pos;
        case (idx)
            4'd0:    pos = 11'd128;
            4'd1:    pos = 11'd261;
            4'd2:    pos = 11'd394;
            4'd3:    pos = 11'd527;
            4'd4:    pos = 11'd660;
            4'd5:    pos = 11'd793;
            4'd6:    pos = 11'd926;
            4'd7:    pos = 11'd1059;
            4'd8:    pos = 11'd1192;
            4'd9:    pos = 11'd1325;
            4'd10:   pos = 11'd1458;
            default: pos = 11'd0;
        endcase
        return pos;
    endfunction

    // Gobo slot positions, floor(k*228.4)+81.
    function automatic logic [10:0] gobo_slot_pos(input logic [2:0] k);
        logic [10:0] pos;
        case (k)
            3'd0:    pos = 11'd81;
            3'd1:    pos = 11'd309;
            3'd2:    pos = 11'd537;
            3'd3:    pos = 11'd766;
            3'd4:    pos = 11'd994;
            3'd5:    pos = 11'd1223;
            3'd6:    pos = 11'd1451;
            default: pos = 11'd81;
        endcase
        return pos;
    endfunction

endpackage

### rtl/dmxmap_calc.sv
// Combinational mapping of one DMX word and the strobe state to one result word.
module dmxmap_calc
    import dmxmap_pkg::*;
(
    input  t_in_word      i_in,
    input  t_strobe_state i_state,
    output t_out_word     o_out,
    output t_strobe_state o_state
);

    logic [14:0] sh1_prod;
    logic [14:0] sh2_prod;
    logic [6:0]  sh1;
    logic [6:0]  sh2;
    logic [14:0] focus_prod;
    logic [7:0]  focus_frac;
    logic [7:0]  strobe_d;
    logic [15:0] strobe_num;
    logic [31:0] strobe_prod;
    logic [9:0]  strobe_q;
    logic [9:0]  interval;
    logic [31:0] elapsed;
    logic        strobe_on;
    logic        fire;
    logic        open_mid;
    logic        open_end;
    logic        at_close;
    logic [11:0] color_x;
    logic [23:0] color_prod;
    logic [2:0]  gobo_k_prod_hi;
    logic [10:0] gobo_k_prod;
    logic [13:0] grot_x;
    logic [26:0] grot_prod;
    logic [9:0]  grot_q;
    logic [6:0]  prism_ofs;
    logic [6:0]  gobo_ofs;

    // Shutter scaling, floor(100*ch/255) and floor(75*ch/255).
    assign sh1_prod = 15'(i_in.shutter_channel) * 15'd100;
    assign sh2_prod = 15'(i_in.shutter_channel) * 15'd75;
    assign sh1      = 7'(div255(16'(sh1_prod)));
    assign sh2      = 7'(div255(16'(sh2_prod)));

    // Focus: ch + floor(80*ch/255) equals floor(335*ch/255).
    assign focus_prod = 15'(i_in.focus_channel) * 15'd80;
    assign focus_frac = div255(16'(focus_prod));

    // Strobe interval is 1000 - ceil(300*d/67) with d = ch - 55.
    assign strobe_d    = i_in.strobe_channel - STROBE_MIN;
    assign strobe_num  = 16'(16'(strobe_d) * 16'd300 + 16'd66);
    assign strobe_prod = 32'(strobe_num) * 32'(RECIP_67_K22);
    assign strobe_q    = strobe_prod[31:22];
    assign interval    = 10'd1000 - strobe_q;
    assign elapsed     = i_in.now_ms - i_state.last_flash;
    assign strobe_on   = (i_in.strobe_channel > STROBE_MIN);
    assign fire        = strobe_on && (elapsed >= 32'(interval));
    assign open_mid    = fire || i_state.open;
    assign at_close    = (i_in.shutter_position == $signed(16'(sh1) + SHUT_CLOSE_OFS));
    assign open_end    = open_mid && !at_close;

    // Next strobe state.
    always_comb begin
        o_state.last_flash = fire ? i_in.now_ms : i_state.last_flash;
        o_state.open       = strobe_on ? open_end : i_state.open;
    end

    // Colour slot index floor(11*ch/201), valid for ch up to 200.
    assign color_x    = 12'(i_in.color_channel) * 12'd11;
    assign color_prod = 24'(color_x) * 24'(RECIP_201_K19);

    // Gobo slot index floor(7*ch/256).
    assign gobo_k_prod    = 11'(i_in.gobo_channel) * 11'd7;
    assign gobo_k_prod_hi = gobo_k_prod[10:8];

    // Gobo rotation position floor(160*ch/11), used for ch up to 55.
    assign grot_x    = 14'(i_in.gobo_rotate_channel[5:0]) * 14'd160;
    assign grot_prod = 27'(grot_x) * 27'(RECIP_11_K16);
    assign grot_q    = grot_prod[25:16];

    // Offset into the active rotation speed band.
    assign prism_ofs = (i_in.prism_rotate_channel > ROT_BAND_SPLIT)
                     ? 7'(i_in.prism_rotate_channel - ROT_BAND_SPLIT)
                     : 7'(i_in.prism_rotate_channel - ROT_LOW_MAX);
    assign gobo_ofs  = (i_in.gobo_rotate_channel > ROT_BAND_SPLIT)
                     ? 7'(i_in.gobo_rotate_channel - ROT_BAND_SPLIT)
                     : 7'(i_in.gobo_rotate_channel - ROT_LOW_MAX);

    // Assemble the result word.
    always_comb begin
        o_out = '0;

        if (strobe_on && !open_end) begin
            o_out.shutter_one_target = 7'd0;
            o_out.shutter_two_target = 7'd0;
        end else begin
            o_out.shutter_one_target = sh1;
            o_out.shutter_two_target = sh2;
        end
        o_out.strobe_toggle = fire;

        o_out.prism_switch_target = (i_in.prism_switch_channel > PRISM_IN_MIN)
                                  ? PRISM_IN_POS : 9'd0;
        o_out.focus_target = 9'(i_in.focus_channel) + 9'(focus_frac);

        if (i_in.prism_rotate_channel > ROT_LOW_MAX) begin
            o_out.prism_rotate_target = (i_in.prism_rotate_channel > ROT_BAND_SPLIT)
                                      ? ROT_FWD : ROT_REV;
            o_out.prism_rotate_speed  = SPD_BASE_P + 13'(prism_ofs) * 13'd45;
        end else begin
            o_out.prism_rotate_target = ROT_STOP;
            o_out.prism_rotate_speed  = PRISM_SPD_IDLE;
        end

        if (i_in.gobo_rotate_channel > ROT_LOW_MAX) begin
            o_out.gobo_rotate_target = (i_in.gobo_rotate_channel > ROT_BAND_SPLIT)
                                     ? ROT_FWD : ROT_REV;
            o_out.gobo_rotate_speed  = SPD_BASE_G + 11'(gobo_ofs) * 11'd10;
        end else begin
            o_out.gobo_rotate_target = $signed({3'b000, grot_q});
            o_out.gobo_rotate_speed  = GOBO_SPD_IDLE;
        end

        if (i_in.color_channel <= COLOR_POS_MAX) begin
            o_out.color_target = $signed({2'b00, color_slot_pos(color_prod[22:19])});
        end else if (i_in.color_channel <= COLOR_REV_MAX) begin
            o_out.color_target = ROT_REV;
        end else begin
            o_out.color_target = ROT_FWD;
        end

        o_out.gobo_target = gobo_slot_pos(gobo_k_prod_hi);
    end

endmodule

### rtl/dmx_channel_to_motor_target_map_unit.sv
// Top level of the DMX channel to motor target map: stream ports, pipeline and strobe state.
//
// Usage:
//   Slave channel (i_s_*): one word per DMX frame carrying the eight channel
//   bytes, the millisecond time and the measured first shutter position.
//   Master channel (o_m_*): one word per input word with the eight motor
//   targets, the prism and gobo rotation speeds and the strobe toggle flag.
//   Pipeline: an accepted word is registered at the input, mapped by one
//   level of constant multiplies and compares, and registered again in
//   the result register that drives o_m_tvalid until i_m_tready takes it.
//   Throughput: one word per cycle while i_m_tready stays high; the strobe
//   timer state is read and updated in the mapping cycle, so consecutive
//   words see each other's effect with no gap.
//   Reset: i_rst_n low clears both pipeline valids, the last flash time and
//   the strobe open flag.
//   Stall: while i_m_tready is held low the result word holds; the input
//   register still takes one more word, after which o_s_tready drops.
module dmx_channel_to_motor_target_map_unit
    import dmxmap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Fields from bit 0: color_channel, shutter_channel, prism_rotate_channel,
    // prism_switch_channel, focus_channel, strobe_channel, gobo_channel,
    // gobo_rotate_channel, now_ms, shutter_position.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // Fields from bit 0: color_target, shutter_one_target, prism_rotate_target,
    // prism_switch_target, focus_target, shutter_two_target, gobo_target,
    // gobo_rotate_target, prism_rotate_speed, gobo_rotate_speed, strobe_toggle,
    // then zero padding.
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready
);

    logic          r_in_valid;
    t_in_word      r_in;
    logic          r_out_valid;
    t_out_word     r_out;
    t_strobe_state r_strobe;
    logic          n_out_valid;
    logic          n_in_valid;
    logic          s_accept;
    logic          advance;
    t_out_word     calc_out;
    t_strobe_state n_strobe;

    // Handshake: a held input word moves on whenever the result register is free or being read.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign n_in_valid  = s_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = advance ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);

    // Mapping logic.
    dmxmap_calc u_calc (
        .i_in    (r_in),
        .i_state (r_strobe),
        .o_out   (calc_out),
        .o_state (n_strobe)
    );

    // Valid flags and strobe state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_strobe.last_flash <= 32'd0;
            r_strobe.open     <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_strobe <= n_strobe;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in <= t_in_word'(i_s_tdata);
        end
        if (advance) begin
            r_out <= calc_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out);

`ifndef SYNTHESIS
    // A flash records the time of the word that fired it.
    a_flash_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && calc_out.strobe_toggle |=> r_strobe.last_flash == $past(r_in.now_ms))
        else $error("last flash time not taken from firing word");

    // Strobe state moves only when a word is mapped.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_strobe))
        else $error("strobe state changed without a word");

    // With the strobe channel at or below threshold nothing fires and state holds.
    a_strobe_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.strobe_channel <= STROBE_MIN)
            |=> $stable(r_strobe) && !r_out.strobe_toggle)
        else $error("strobe acted while disabled");

    // Input is refused only when both stages hold words.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && r_out_valid && !i_m_tready)
        else $error("input refused with room in the pipeline");
`endif

endmodule

### verif/tb_dmx_channel_to_motor_target_map_unit.sv
// Self-checking testbench for the DMX channel to motor target map stream unit.
`timescale 1ns / 100ps

module tb_dmx_channel_to_motor_target_map_unit;
    import dmxmap_pkg::*;

    localparam real CLK_HALF_NS   = 6.0;
    localparam int  RESET_CYCLES  = 5;
    localparam int  RANDOM_WORDS  = 1730;
    localparam int  IDLE_PCT      = 21;
    localparam int  HOLD_AFTER    = 300;
    localparam int  HOLD_CYCLES   = 80;
    localparam int  BUSY_FIRST    = 1000;
    localparam int  BUSY_LAST     = 1300;
    localparam int  DRAIN_AT      = 700;
    localparam int  TAIL_CYCLES   = 8;
    localparam int  LIMIT_CYCLES  = 200000;
    localparam int  COLOR_SLOT [11] = '{128, 261, 394, 527, 660, 793, 926, 1059, 1192,
                                        1325, 1458};

    typedef struct {
        t_in_word  frm;
        bit        typed;
        t_out_word want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    // Fields from bit 0: color_channel, shutter_channel, prism_rotate_channel,
    // prism_switch_channel, focus_channel, strobe_channel, gobo_channel,
    // gobo_rotate_channel, now_ms, shutter_position.
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // Fields from bit 0: color_target, shutter_one_target, prism_rotate_target,
    // prism_switch_target, focus_target, shutter_two_target, gobo_target,
    // gobo_rotate_target, prism_rotate_speed, gobo_rotate_speed, strobe_toggle.
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;

    // Expected target words, oldest first.
    t_out_word   pending_targets [$];
    t_dir_row    dir_rows [$];
    int          errors;
    int          words_out;
    int          hold_left;
    bit          hold_done;
    // Predicted strobe timer state.
    logic [31:0] strobe_last_ms;
    bit          strobe_is_open;
    t_out_word   got_word;
    t_out_word   want_word;

    dmx_channel_to_motor_target_map_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tdata  = '0;
        i_s_tvalid = 1'b0;
        i_m_tready = 1'b0;
    end

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Build one DMX frame word.
    function automatic t_in_word frame(input int cc, input int sh, input int pr, input int ps,
                                       input int fc, input int st, input int gb, input int gr,
                                       input logic [31:0] now, input int pos);
        t_in_word f;
        f.color_channel        = 8'(cc);
        f.shutter_channel      = 8'(sh);
        f.prism_rotate_channel = 8'(pr);
        f.prism_switch_channel = 8'(ps);
        f.focus_channel        = 8'(fc);
        f.strobe_channel       = 8'(st);
        f.gobo_channel         = 8'(gb);
        f.gobo_rotate_channel  = 8'(gr);
        f.now_ms               = now;
        f.shutter_position     = 16'(pos);
        return f;
    endfunction

    // Build one target word from plain values.
    function automatic t_out_word targets(input int color, input int sh1, input int prot,
                                          input int psw, input int foc, input int sh2,
                                          input int gobo, input int grot, input int pspd,
                                          input int gspd, input int tog);
        t_out_word r;
        r = '0;
        r.color_target        = 13'(color);
        r.shutter_one_target  = 7'(sh1);
        r.prism_rotate_target = 13'(prot);
        r.prism_switch_target = 9'(psw);
        r.focus_target        = 9'(foc);
        r.shutter_two_target  = 7'(sh2);
        r.gobo_target         = 11'(gobo);
        r.gobo_rotate_target  = 13'(grot);
        r.prism_rotate_speed  = 13'(pspd);
        r.gobo_rotate_speed   = 11'(gspd);
        r.strobe_toggle       = tog[0];
        return r;
    endfunction

    task automatic add_row(input t_in_word f, input bit typed, input t_out_word w);
        t_dir_row row;
        row.frm   = f;
        row.typed = typed;
        row.want  = w;
        dir_rows.push_back(row);
    endtask

    // Upper rotation bands: reverse up to 155, forward above it.
    task automatic rotate_band(input int ch, input int step, output int target,
                               output int speed);
        if (ch > ROT_BAND_SPLIT) begin
            target = 3000;
            speed  = 500 + step * (ch - ROT_BAND_SPLIT);
        end else begin
            target = -3000;
            speed  = 500 + step * (ch - ROT_LOW_MAX);
        end
    endtask

    // Compute the target word for one frame and advance the strobe timer.
    task automatic map_frame(input t_in_word f, output t_out_word r);
        int cc, sh, pr, ps, fc, st, gb, gr, pos;
        int sh1, sh2, interval, color, prot, pspd, grot, gspd;
        logic [31:0] since;
        cc  = f.color_channel;
        sh  = f.shutter_channel;
        pr  = f.prism_rotate_channel;
        ps  = f.prism_switch_channel;
        fc  = f.focus_channel;
        st  = f.strobe_channel;
        gb  = f.gobo_channel;
        gr  = f.gobo_rotate_channel;
        pos = f.shutter_position;
        r   = '0;

        sh1 = (100 * sh) / 255;
        sh2 = (75 * sh) / 255;

        // Strobe timer: fire when the interval has elapsed, close once the shutter is there.
        if (st > STROBE_MIN) begin
            interval = (201000 - 900 * (st - 55)) / 201;
            since    = f.now_ms - strobe_last_ms;
            if (since >= 32'(interval)) begin
                strobe_last_ms  = f.now_ms;
                strobe_is_open  = 1'b1;
                r.strobe_toggle = 1'b1;
            end
            if (strobe_is_open && pos == sh1 + 100)
                strobe_is_open = 1'b0;
            if (!strobe_is_open) begin
                sh1 = 0;
                sh2 = 0;
            end
        end

        if (pr > ROT_LOW_MAX) begin
            rotate_band(pr, 45, prot, pspd);
        end else begin
            prot = 0;
            pspd = 5000;
        end

        if (gr > ROT_LOW_MAX) begin
            rotate_band(gr, 10, grot, gspd);
        end else begin
            grot = (800 * gr) / 55;
            gspd = 1500;
        end

        if (cc <= COLOR_POS_MAX)
            color = COLOR_SLOT[(11 * cc) / 201];
        else if (cc <= COLOR_REV_MAX)
            color = -3000;
        else
            color = 3000;

        r.color_target        = 13'(color);
        r.shutter_one_target  = 7'(sh1);
        r.prism_rotate_target = 13'(prot);
        r.prism_switch_target = (ps > PRISM_IN_MIN) ? 9'd257 : 9'd0;
        r.focus_target        = 9'((335 * fc) / 255);
        r.shutter_two_target  = 7'(sh2);
        r.gobo_target         = 11'((((7 * gb) / 256) * 2284) / 10 + 81);
        r.gobo_rotate_target  = 13'(grot);
        r.prism_rotate_speed  = 13'(pspd);
        r.gobo_rotate_speed   = 11'(gspd);
    endtask

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_frame(input t_in_word f, input bit may_idle);
        @(negedge i_clk);
        while (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= f;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic drain;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_targets.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result side: one long hold-off, one stretch with no stalls, random stalls otherwise.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (!hold_done && words_out >= HOLD_AFTER) begin
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES - 1;
            hold_done  <= 1'b1;
        end else if (words_out >= BUSY_FIRST && words_out < BUSY_LAST) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_word = o_m_tdata;
            if (pending_targets.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
            end else begin
                want_word = pending_targets.pop_front();
                check_field("color_target", want_word.color_target, got_word.color_target);
                check_field("shutter_one_target", want_word.shutter_one_target,
                            got_word.shutter_one_target);
                check_field("prism_rotate_target", want_word.prism_rotate_target,
                            got_word.prism_rotate_target);
                check_field("prism_switch_target", want_word.prism_switch_target,
                            got_word.prism_switch_target);
                check_field("focus_target", want_word.focus_target, got_word.focus_target);
                check_field("shutter_two_target", want_word.shutter_two_target,
                            got_word.shutter_two_target);
                check_field("gobo_target", want_word.gobo_target, got_word.gobo_target);
                check_field("gobo_rotate_target", want_word.gobo_rotate_target,
                            got_word.gobo_rotate_target);
                check_field("prism_rotate_speed", want_word.prism_rotate_speed,
                            got_word.prism_rotate_speed);
                check_field("gobo_rotate_speed", want_word.gobo_rotate_speed,
                            got_word.gobo_rotate_speed);
                check_field("strobe_toggle", want_word.strobe_toggle, got_word.strobe_toggle);
            end
            words_out++;
        end
    end

    // Main sequence: reset, directed frames, then random frames.
    initial begin
        t_in_word    f;
        t_out_word   w;
        logic [31:0] clock_ms;
        int          sh, kind;
        errors         = 0;
        words_out      = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        strobe_last_ms = '0;
        strobe_is_open = 1'b0;
        clock_ms       = 32'd5000;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All channels at zero straight after reset.
        add_row(frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                targets(128, 0, 0, 0, 0, 0, 81, 0, 5000, 1500, 0));
        // All channels full, timer not yet elapsed: shutters stay closed.
        add_row(frame(255, 255, 255, 255, 255, 255, 255, 255, 0, 0), 1'b1,
                targets(3000, 0, 3000, 257, 335, 0, 1451, 3000, 5000, 1500, 0));
        // Time at its top value: the strobe fires and opens.
        add_row(frame(255, 255, 255, 255, 255, 255, 255, 255, 32'hFFFF_FFFF, -32768), 1'b1,
                targets(3000, 100, 3000, 257, 335, 75, 1451, 3000, 5000, 1500, 1));
        // Time wrapped, one short of the interval; shutter reached its close position.
        add_row(frame(255, 255, 255, 255, 255, 255, 255, 255, 102, 200), 1'b1,
                targets(3000, 0, 3000, 257, 335, 0, 1451, 3000, 5000, 1500, 0));
        // Interval reached across the wrap: fires and closes in the same frame.
        add_row(frame(255, 255, 255, 255, 255, 255, 255, 255, 103, 200), 1'b1,
                targets(3000, 0, 3000, 257, 335, 0, 1451, 3000, 5000, 1500, 1));
        // Band edges of every channel.
        add_row(frame(200, 128, 55, 125, 128, 55, 36, 55, 500, 0), 1'b0, '0);
        add_row(frame(201, 1, 56, 126, 1, 56, 37, 56, 600, 32767), 1'b0, '0);
        add_row(frame(224, 254, 155, 127, 254, 100, 73, 155, 1200, 100), 1'b0, '0);
        add_row(frame(225, 127, 156, 0, 127, 200, 74, 156, 1300, -1), 1'b0, '0);
        add_row(frame(18, 200, 100, 200, 77, 56, 110, 200, 2000, 178), 1'b0, '0);
        add_row(frame(19, 50, 0, 0, 0, 255, 146, 0, 2001, 119), 1'b0, '0);
        add_row(frame(100, 51, 200, 0, 200, 255, 147, 30, 2105, 0), 1'b0, '0);
        add_row(frame(100, 51, 200, 0, 200, 255, 182, 30, 2106, 0), 1'b0, '0);
        add_row(frame(36, 51, 56, 126, 10, 255, 183, 54, 2107, 120), 1'b0, '0);
        // Strobe off: shutters follow the channel even though the flag is clear.
        add_row(frame(37, 255, 155, 125, 255, 0, 219, 1, 2108, 200), 1'b0, '0);
        add_row(frame(37, 255, 156, 125, 255, 56, 220, 254, 2108, 201), 1'b0, '0);
        add_row(frame(92, 170, 254, 255, 170, 57, 255, 255, 32'h8000_0000, -100), 1'b0, '0);
        add_row(frame(93, 170, 254, 255, 170, 57, 255, 255, 32'h8000_03E0, 166), 1'b0, '0);

        foreach (dir_rows[i]) begin
            send_frame(dir_rows[i].frm, 1'b1);
            map_frame(dir_rows[i].frm, w);
            pending_targets.push_back(dir_rows[i].typed ? dir_rows[i].want : w);
        end
        drain();

        // Random frames: mostly a running clock with the strobe busy, some pure noise.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == DRAIN_AT)
                drain();
            kind = $urandom_range(0, 99);
            sh   = $urandom_range(0, 255);
            if (kind < 10) begin
                f = frame($urandom_range(0, 255), sh, $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom(), $urandom());
            end else begin
                clock_ms = (kind < 13) ? $urandom() : clock_ms + $urandom_range(0, 150);
                f = frame($urandom_range(0, 255), sh, $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          (kind < 80) ? $urandom_range(56, 255) : $urandom_range(0, 55),
                          $urandom_range(0, 255), $urandom_range(0, 255), clock_ms,
                          ($urandom_range(0, 99) < 45) ? (100 * sh) / 255 + 100 : $urandom());
            end
            send_frame(f, !(n >= BUSY_FIRST && n < BUSY_LAST));
            map_frame(f, w);
            pending_targets.push_back(w);
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit.
    initial begin
        #(2.0 * CLK_HALF_NS * LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### dmx_channel_to_motor_target_map_unit.f
rtl/dmxmap_pkg.sv
rtl/dmxmap_calc.sv
rtl/dmx_channel_to_motor_target_map_unit.sv
verif/tb_dmx_channel_to_motor_target_map_unit.sv
